// ===== hw/rtl/sff_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package sff_pkg;

   localparam int CORDIC_STAGES = 32;
   localparam int DIV_BITS      = 64;
   localparam int D_WIDTH       = 93;   // q^3, Q.72
   localparam int P_WIDTH       = 140;  // scaled numerator
   localparam int SH_WIDTH      = D_WIDTH + DIV_BITS;

   localparam logic [63:0] PI_Q62             = 64'hC90FDAA22168C235;
   localparam logic [63:0] HALF_PI_Q62        = PI_Q62 >> 1;
   localparam logic [63:0] FOUR_THIRDS_PI_Q60 = PI_Q62 / 3;
   localparam logic [63:0] TWO_OVER_PI_Q64    = 64'hA2F9836E4E44152A;
   localparam logic [63:0] INV_GAIN_Q62       = 64'd2800459870029452989;
   localparam logic [62:0] ONE_Q62            = 63'h4000000000000000;
   localparam logic [63:0] SERIES_LIMIT       = 64'd109951163;

   localparam int DIV10_SHIFT  = 40;
   localparam int DIV280_SHIFT = 20;
   localparam logic [36:0] DIV10_RECIP  = 37'((64'd1 << DIV10_SHIFT) / 10);
   localparam logic [11:0] DIV280_RECIP = 12'((64'd1 << DIV280_SHIFT) / 280);

   localparam logic [63:0] AMP_MAX = 64'h7FFFFFFFFFFFFFFF;
   localparam logic [63:0] AMP_MIN = 64'h8000000000000000;

   localparam logic [1:0] ERR_OK    = 2'd0;
   localparam logic [1:0] ERR_NEG_Q = 2'd1;
   localparam logic [1:0] ERR_NEG_R = 2'd2;

   localparam logic [1:0]  REG_RADIUS   = 2'd0;
   localparam logic [1:0]  REG_CONTRAST = 2'd1;
   localparam logic [31:0] REG_RESET    = 32'd65536;

   // 32x32 partial products of a 192-bit by 64-bit multiply
   typedef logic [11:0][63:0] pp_type;

   typedef struct packed {
      logic                 valid;
      logic [1:0]           err;
      logic                 cneg;
      logic                 series;
      logic [63:0]          m_series;
      logic                 big_series;
      logic [61:0]          x;
      logic [31:0]          cmag;
      logic [D_WIDTH-1:0]   d;
      logic [1:0]           quad;
   } meta_type;

   function automatic pp_type mul_pp(input logic [191:0] a, input logic [63:0] b);
      pp_type p;
      for (int i = 0; i < 6; i++) begin
         for (int j = 0; j < 2; j++) begin
            p[i*2+j] = {32'd0, a[i*32 +: 32]} * {32'd0, b[j*32 +: 32]};
         end
      end
      return p;
   endfunction

   function automatic logic [255:0] pp_sum(input pp_type p);
      logic [255:0] s;
      s = '0;
      for (int i = 0; i < 6; i++) begin
         for (int j = 0; j < 2; j++) begin
            s = s + (256'(p[i*2+j]) << (32 * (i + j)));
         end
      end
      return s;
   endfunction

   // atan(2^-i) in Q.62, alternating series with truncated terms
   function automatic logic [63:0] atan_q62(input int i);
      logic [63:0] acc;
      logic [63:0] term;
      int          e;
      acc = '0;
      if (i == 0) begin
         return PI_Q62 >> 2;
      end
      for (int k = 0; k < 64; k++) begin
         e = 62 - i * (2 * k + 1);
         if (e >= 0) begin
            term = (64'd1 << e) / 64'(2 * k + 1);
            acc  = k[0] ? acc - term : acc + term;
         end
      end
      return acc;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/sff_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sff_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire logic [31:0]       in_q,
   input  wire logic [31:0]       radius,
   input  wire logic [31:0]       contrast,
   output sff_pkg::meta_type      out_meta,
   output logic [63:0]            out_angle
);
   import sff_pkg::*;

   localparam int STAGES = 10;

   typedef struct packed {
      logic                valid;
      logic [1:0]          err;
      logic                cneg;
      logic [31:0]         cmag;
      logic [31:0]         q;
      logic [31:0]         rv;
      logic [63:0]         x;
      logic                series;
      logic [35:0]         x2;
      logic [32:0]         d10;
      logic [9:0]          x4;
      logic [2:0]          e280;
      logic [62:0]         poly;
      logic [63:0]         cr;
      logic [95:0]         c3;
      logic [127:0]        c4;
      logic [191:0]        c5;
      logic [63:0]         m_series;
      logic                big_series;
      logic [63:0]         qq;
      logic [D_WIDTH-1:0]  d;
      logic [125:0]        t;
      logic [1:0]          quad;
      logic [63:0]         r;
      pp_type              pp_c;
      pp_type              pp_t;
      pp_type              pp_d;
   } front_type;

   front_type st_in [1:STAGES];
   front_type st_ff [1:STAGES];

   always_comb begin
      logic [53:0]  sqx;
      logic [71:0]  p44;
      logic [72:0]  p10;
      logic [35:0]  rem10;
      logic [21:0]  p280;
      logic [9:0]   rem280;
      logic [2:0]   d280;
      logic [255:0] s_c;
      logic [255:0] s_t;
      logic [255:0] s_d;

      // stage 1: error check, contrast magnitude, x = q*R (Q.40)
      st_in[1]       = '0;
      st_in[1].valid = in_valid;
      st_in[1].q     = in_q;
      st_in[1].rv    = radius;
      st_in[1].cneg  = contrast[31];
      st_in[1].cmag  = contrast[31] ? 32'(33'h100000000 - {1'b0, contrast}) : contrast;
      st_in[1].x     = 64'(in_q) * 64'(radius);
      if (in_q[31]) begin
         st_in[1].err = ERR_NEG_Q;
      end else if (radius[31]) begin
         st_in[1].err = ERR_NEG_R;
      end else begin
         st_in[1].err = ERR_OK;
      end

      // stage 2
      st_in[2]        = st_ff[1];
      st_in[2].series = st_ff[1].x < SERIES_LIMIT;
      sqx             = 54'(st_ff[1].x[26:0]) * 54'(st_ff[1].x[26:0]);
      st_in[2].x2     = sqx[53:18];
      st_in[2].cr     = 64'(st_ff[1].cmag) * 64'(st_ff[1].rv);
      st_in[2].pp_t   = mul_pp(192'(st_ff[1].x), TWO_OVER_PI_Q64);
      st_in[2].qq     = 64'(st_ff[1].q) * 64'(st_ff[1].q);

      // stage 3
      st_in[3]      = st_ff[2];
      p44           = 72'(st_ff[2].x2) * 72'(st_ff[2].x2);
      st_in[3].x4   = p44[71:62];
      p10           = 73'(st_ff[2].x2) * 73'(DIV10_RECIP);
      st_in[3].d10  = p10[72:40];
      st_in[3].pp_c = mul_pp(192'(st_ff[2].cr), 64'(st_ff[2].rv));
      s_t           = pp_sum(st_ff[2].pp_t);
      st_in[3].t    = s_t[125:0];
      st_in[3].pp_d = mul_pp(192'(st_ff[2].qq), 64'(st_ff[2].q));

      // stage 4: fix the x2/10 estimate, quadrant split
      st_in[4]      = st_ff[3];
      rem10         = st_ff[3].x2 - ((36'(st_ff[3].d10) << 3) + (36'(st_ff[3].d10) << 1));
      st_in[4].d10  = st_ff[3].d10 + 33'(rem10 >= 36'd10);
      p280          = 22'(st_ff[3].x4) * 22'(DIV280_RECIP);
      st_in[4].e280 = {1'b0, p280[21:20]};
      s_c           = pp_sum(st_ff[3].pp_c);
      st_in[4].c3   = s_c[95:0];
      s_d           = pp_sum(st_ff[3].pp_d);
      st_in[4].d    = s_d[D_WIDTH-1:0];
      st_in[4].quad = st_ff[3].t[105:104];
      st_in[4].pp_t = mul_pp(192'(st_ff[3].t[103:42]), HALF_PI_Q62);

      // stage 5: polynomial (x^6 term is below one lsb here), angle
      st_in[5]      = st_ff[4];
      rem280        = st_ff[4].x4 - 10'({7'd0, st_ff[4].e280} * 10'd280);
      d280          = st_ff[4].e280 + 3'(rem280 >= 10'd280);
      st_in[5].poly = ONE_Q62 - 63'(st_ff[4].d10) + 63'(d280);
      st_in[5].pp_c = mul_pp(192'(st_ff[4].c3), 64'(st_ff[4].rv));
      s_t           = pp_sum(st_ff[4].pp_t);
      st_in[5].r    = s_t[125:62];

      // stage 6..10: c*R^3 * (4/3)pi * poly
      st_in[6]      = st_ff[5];
      s_c           = pp_sum(st_ff[5].pp_c);
      st_in[6].c4   = s_c[127:0];

      st_in[7]      = st_ff[6];
      st_in[7].pp_c = mul_pp(192'(st_ff[6].c4), FOUR_THIRDS_PI_Q60);

      st_in[8]      = st_ff[7];
      s_c           = pp_sum(st_ff[7].pp_c);
      st_in[8].c5   = s_c[191:0];

      st_in[9]      = st_ff[8];
      st_in[9].pp_c = mul_pp(st_ff[8].c5, 64'(st_ff[8].poly));

      st_in[10]            = st_ff[9];
      s_c                  = pp_sum(st_ff[9].pp_c);
      st_in[10].m_series   = s_c[225:162];
      st_in[10].big_series = |s_c[255:226];
   end

   always_ff @(posedge clock) begin
      for (int k = 1; k <= STAGES; k++) begin
         if (reset) begin
            st_ff[k].valid <= 1'b0;
         end else begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   always_comb begin
      out_meta            = '0;
      out_meta.valid      = st_ff[STAGES].valid;
      out_meta.err        = st_ff[STAGES].err;
      out_meta.cneg       = st_ff[STAGES].cneg;
      out_meta.series     = st_ff[STAGES].series;
      out_meta.m_series   = st_ff[STAGES].m_series;
      out_meta.big_series = st_ff[STAGES].big_series;
      out_meta.x          = st_ff[STAGES].x[61:0];
      out_meta.cmag       = st_ff[STAGES].cmag;
      out_meta.d          = st_ff[STAGES].d;
      out_meta.quad       = st_ff[STAGES].quad;
   end

   assign out_angle = st_ff[STAGES].r;

endmodule
`default_nettype wire

// ===== hw/rtl/sff_cordic.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sff_cordic (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire sff_pkg::meta_type in_meta,
   input  wire logic [63:0]       in_angle,
   output sff_pkg::meta_type      out_meta,
   output logic [63:0]            out_sin,
   output logic [63:0]            out_cos
);
   import sff_pkg::*;

   logic [63:0] cx_s [0:CORDIC_STAGES];
   logic [63:0] cy_s [0:CORDIC_STAGES];
   logic [63:0] cz_s [0:CORDIC_STAGES];
   meta_type    cm_s [0:CORDIC_STAGES];

   logic [63:0] cx_in [0:CORDIC_STAGES-1];
   logic [63:0] cy_in [0:CORDIC_STAGES-1];
   logic [63:0] cz_in [0:CORDIC_STAGES-1];
   logic [63:0] cx_ff [0:CORDIC_STAGES-1];
   logic [63:0] cy_ff [0:CORDIC_STAGES-1];
   logic [63:0] cz_ff [0:CORDIC_STAGES-1];
   meta_type    cm_ff [0:CORDIC_STAGES-1];

   assign cx_s[0] = INV_GAIN_Q62;
   assign cy_s[0] = '0;
   assign cz_s[0] = in_angle;
   assign cm_s[0] = in_meta;

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
      localparam logic [63:0] ATAN = atan_q62(i);
      logic [63:0] xs;
      logic [63:0] ys;

      assign xs = $unsigned($signed(cx_s[i]) >>> i);
      assign ys = $unsigned($signed(cy_s[i]) >>> i);

      always_comb begin
         if (!cz_s[i][63]) begin
            cx_in[i] = cx_s[i] - ys;
            cy_in[i] = cy_s[i] + xs;
            cz_in[i] = cz_s[i] - ATAN;
         end else begin
            cx_in[i] = cx_s[i] + ys;
            cy_in[i] = cy_s[i] - xs;
            cz_in[i] = cz_s[i] + ATAN;
         end
      end

      always_ff @(posedge clock) begin
         cx_ff[i] <= cx_in[i];
         cy_ff[i] <= cy_in[i];
         cz_ff[i] <= cz_in[i];
         if (reset) begin
            cm_ff[i].valid <= 1'b0;
         end else begin
            cm_ff[i] <= cm_s[i];
         end
      end

      assign cx_s[i+1] = cx_ff[i];
      assign cy_s[i+1] = cy_ff[i];
      assign cz_s[i+1] = cz_ff[i];
      assign cm_s[i+1] = cm_ff[i];
   end

   assign out_meta = cm_s[CORDIC_STAGES];
   assign out_sin  = cy_s[CORDIC_STAGES];
   assign out_cos  = cx_s[CORDIC_STAGES];

endmodule
`default_nettype wire

// ===== hw/rtl/sff_post.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sff_post (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire sff_pkg::meta_type        in_meta,
   input  wire logic [63:0]              in_sin,
   input  wire logic [63:0]              in_cos,
   output sff_pkg::meta_type             out_meta,
   output logic [sff_pkg::P_WIDTH-1:0]   out_p,
   output logic                          out_big,
   output logic                          out_nneg
);
   import sff_pkg::*;

   localparam int STAGES = 10;

   typedef struct packed {
      meta_type            meta;
      logic [63:0]         sv;
      logic [63:0]         cv;
      logic [63:0]         a;
      logic [63:0]         cabs;
      logic                sneg;
      logic                cosneg;
      logic [84:0]         b;
      logic [85:0]         nm;
      logic                nneg;
      logic [117:0]        n1;
      logic [P_WIDTH-1:0]  p;
      logic                big;
      pp_type              pp;
   } post_type;

   post_type st_in [1:STAGES];
   post_type st_ff [1:STAGES];

   always_comb begin
      logic [255:0] s;
      logic [85:0]  a_w;
      logic [85:0]  b_w;
      logic         bneg;

      // stage 1: undo the quadrant reduction
      st_in[1]      = '0;
      st_in[1].meta = in_meta;
      case (in_meta.quad)
         2'd0: begin
            st_in[1].sv = in_sin;
            st_in[1].cv = in_cos;
         end
         2'd1: begin
            st_in[1].sv = in_cos;
            st_in[1].cv = -in_sin;
         end
         2'd2: begin
            st_in[1].sv = -in_sin;
            st_in[1].cv = -in_cos;
         end
         default: begin
            st_in[1].sv = -in_cos;
            st_in[1].cv = in_sin;
         end
      endcase

      // stage 2: magnitudes
      st_in[2]        = st_ff[1];
      st_in[2].sneg   = st_ff[1].sv[63];
      st_in[2].cosneg = st_ff[1].cv[63];
      st_in[2].a      = st_ff[1].sv[63] ? -st_ff[1].sv : st_ff[1].sv;
      st_in[2].cabs   = st_ff[1].cv[63] ? -st_ff[1].cv : st_ff[1].cv;

      // stage 3..4: x*|cos| >> 40
      st_in[3]    = st_ff[2];
      st_in[3].pp = mul_pp(192'(st_ff[2].meta.x), st_ff[2].cabs);

      st_in[4]   = st_ff[3];
      s          = pp_sum(st_ff[3].pp);
      st_in[4].b = s[124:40];

      // stage 5: sign-magnitude sin - x*cos
      st_in[5] = st_ff[4];
      a_w      = 86'(st_ff[4].a);
      b_w      = 86'(st_ff[4].b);
      bneg     = !st_ff[4].cosneg;
      if (st_ff[4].sneg == bneg) begin
         st_in[5].nm   = a_w + b_w;
         st_in[5].nneg = st_ff[4].sneg;
      end else if (a_w >= b_w) begin
         st_in[5].nm   = a_w - b_w;
         st_in[5].nneg = st_ff[4].sneg;
      end else begin
         st_in[5].nm   = b_w - a_w;
         st_in[5].nneg = bneg;
      end

      // stage 6..9: |c| * 4pi * num >> 42
      st_in[6]    = st_ff[5];
      st_in[6].pp = mul_pp(192'(st_ff[5].nm), 64'(st_ff[5].meta.cmag));

      st_in[7]    = st_ff[6];
      s           = pp_sum(st_ff[6].pp);
      st_in[7].n1 = s[117:0];

      st_in[8]    = st_ff[7];
      st_in[8].pp = mul_pp(192'(st_ff[7].n1), PI_Q62);

      st_in[9]   = st_ff[8];
      s          = pp_sum(st_ff[8].pp);
      st_in[9].p = s[P_WIDTH+41:42];

      // stage 10: quotient would not fit 64 bits
      st_in[10]     = st_ff[9];
      st_in[10].big = SH_WIDTH'(st_ff[9].p) >= {st_ff[9].meta.d, DIV_BITS'(0)};
   end

   always_ff @(posedge clock) begin
      for (int k = 1; k <= STAGES; k++) begin
         if (reset) begin
            st_ff[k].meta.valid <= 1'b0;
         end else begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   assign out_meta = st_ff[STAGES].meta;
   assign out_p    = st_ff[STAGES].p;
   assign out_big  = st_ff[STAGES].big;
   assign out_nneg = st_ff[STAGES].nneg;

endmodule
`default_nettype wire

// ===== hw/rtl/sff_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sff_divider (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire sff_pkg::meta_type          in_meta,
   input  wire logic [sff_pkg::P_WIDTH-1:0] in_p,
   input  wire logic                       in_big,
   input  wire logic                       in_nneg,
   output sff_pkg::meta_type               out_meta,
   output logic [sff_pkg::DIV_BITS-1:0]    out_quo,
   output logic                            out_big,
   output logic                            out_nneg
);
   import sff_pkg::*;

   typedef struct packed {
      meta_type            meta;
      logic [P_WIDTH-1:0]  rem;
      logic [DIV_BITS-1:0] quo;
      logic                big;
      logic                nneg;
   } div_type;

   div_type dv_s  [0:DIV_BITS];
   div_type dv_in [0:DIV_BITS-1];
   div_type dv_ff [0:DIV_BITS-1];

   assign dv_s[0] = '{meta: in_meta, rem: in_p, quo: '0, big: in_big, nneg: in_nneg};

   // restoring division, one quotient bit per stage, msb first
   for (genvar j = 0; j < DIV_BITS; j++) begin : g_bit
      localparam int BIT = DIV_BITS - 1 - j;
      logic [SH_WIDTH-1:0] sh;
      logic [SH_WIDTH-1:0] diff;
      logic                ge;

      assign sh   = SH_WIDTH'(dv_s[j].meta.d) << BIT;
      assign ge   = SH_WIDTH'(dv_s[j].rem) >= sh;
      assign diff = SH_WIDTH'(dv_s[j].rem) - sh;

      always_comb begin
         dv_in[j] = dv_s[j];
         dv_in[j].quo[BIT] = ge;
         if (ge) begin
            dv_in[j].rem = diff[P_WIDTH-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[j].meta.valid <= 1'b0;
         end else begin
            dv_ff[j] <= dv_in[j];
         end
      end

      assign dv_s[j+1] = dv_ff[j];
   end

   assign out_meta = dv_s[DIV_BITS].meta;
   assign out_quo  = dv_s[DIV_BITS].quo;
   assign out_big  = dv_s[DIV_BITS].big;
   assign out_nneg = dv_s[DIV_BITS].nneg;

endmodule
`default_nettype wire

// ===== hw/rtl/sphere_form_factor.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Homogeneous sphere form factor: amplitude and intensity per scattering vector.
// The result strobe follows the accepting edge through the front, the CORDIC chain,
// the post block, the 64-stage bit-per-stage divider and the finish registers.
// Throughput: one beat per cycle; busy stays low, the receiver cannot stall the output.
// Reset (synchronous, active high) clears all valid bits and sets radius and
// contrast to 1.0; in-flight beats are dropped.
module sphere_form_factor (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output logic              busy,
   input  wire logic [31:0]  req_q_value,
   output logic              rsp_strobe,
   output logic [63:0]       rsp_amplitude,
   output logic [63:0]       rsp_intensity,
   output logic [1:0]        rsp_error_code,
   output logic              rsp_saturated,
   input  wire logic         csr_write_enable,
   input  wire logic [1:0]   csr_index,
   input  wire logic [31:0]  csr_write_data
);
   import sff_pkg::*;

   // ---------------- configuration registers ----------------
   logic [31:0] radius_ff, radius_in;
   logic [31:0] contrast_ff, contrast_in;

   always_comb begin
      radius_in   = radius_ff;
      contrast_in = contrast_ff;
      if (csr_write_enable) begin
         case (csr_index)
            REG_RADIUS:   radius_in   = csr_write_data;
            REG_CONTRAST: contrast_in = csr_write_data;
            default:      ;  // unknown index: write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff   <= REG_RESET;
         contrast_ff <= REG_RESET;
      end else begin
         radius_ff   <= radius_in;
         contrast_ff <= contrast_in;
      end
   end

   // fully pipelined: a new beat is taken every cycle
   assign busy = 1'b0;

   // ---------------- datapath ----------------
   // front: error check, x = qR, series branch, range reduction, q^3
   meta_type    fr_meta;
   logic [63:0] fr_angle;

   sff_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .in_q      (req_q_value),
      .radius    (radius_ff),
      .contrast  (contrast_ff),
      .out_meta  (fr_meta),
      .out_angle (fr_angle)
   );

   // sin/cos of the reduced angle, one rotation per stage
   meta_type    co_meta;
   logic [63:0] co_sin;
   logic [63:0] co_cos;

   sff_cordic u_cordic (
      .clock    (clock),
      .reset    (reset),
      .in_meta  (fr_meta),
      .in_angle (fr_angle),
      .out_meta (co_meta),
      .out_sin  (co_sin),
      .out_cos  (co_cos)
   );

   // numerator sin x - x cos x, scaled by |c|*4pi, overflow test
   meta_type           po_meta;
   logic [P_WIDTH-1:0] po_p;
   logic               po_big;
   logic               po_nneg;

   sff_post u_post (
      .clock    (clock),
      .reset    (reset),
      .in_meta  (co_meta),
      .in_sin   (co_sin),
      .in_cos   (co_cos),
      .out_meta (po_meta),
      .out_p    (po_p),
      .out_big  (po_big),
      .out_nneg (po_nneg)
   );

   // divide by q^3
   meta_type            dv_meta;
   logic [DIV_BITS-1:0] dv_quo;
   logic                dv_big;
   logic                dv_nneg;

   sff_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .in_meta  (po_meta),
      .in_p     (po_p),
      .in_big   (po_big),
      .in_nneg  (po_nneg),
      .out_meta (dv_meta),
      .out_quo  (dv_quo),
      .out_big  (dv_big),
      .out_nneg (dv_nneg)
   );

   // ---------------- finish: branch select, sign, saturation, square ----------------
   logic        f1_valid_ff, f1_valid_in;
   logic [1:0]  f1_err_ff, f1_err_in;
   logic        f1_neg_ff, f1_neg_in;
   logic        f1_big_ff, f1_big_in;
   logic [63:0] f1_m_ff, f1_m_in;

   logic        f2_valid_ff, f2_valid_in;
   logic [1:0]  f2_err_ff, f2_err_in;
   logic        f2_big_ff, f2_big_in;
   logic [63:0] f2_amp_ff, f2_amp_in;
   logic        f2_sat_ff, f2_sat_in;
   pp_type      f2_pp_ff, f2_pp_in;

   logic        rsp_strobe_ff, rsp_strobe_in;
   logic [63:0] rsp_amplitude_ff, rsp_amplitude_in;
   logic [63:0] rsp_intensity_ff, rsp_intensity_in;
   logic [1:0]  rsp_error_code_ff, rsp_error_code_in;
   logic        rsp_saturated_ff, rsp_saturated_in;

   logic [255:0] sq;
   logic         sq_over;

   always_comb begin
      // pick the series or the trig result
      f1_valid_in = dv_meta.valid;
      f1_err_in   = dv_meta.err;
      if (dv_meta.series) begin
         f1_m_in   = dv_meta.m_series;
         f1_big_in = dv_meta.big_series;
         f1_neg_in = dv_meta.cneg;
      end else begin
         f1_m_in   = dv_quo;
         f1_big_in = dv_big;
         f1_neg_in = dv_meta.cneg != dv_nneg;
      end

      // signed clip of the amplitude; square partial products
      f2_valid_in = f1_valid_ff;
      f2_err_in   = f1_err_ff;
      f2_big_in   = f1_big_ff;
      f2_pp_in    = mul_pp(192'(f1_m_ff), f1_m_ff);
      if (f1_big_ff || (!f1_neg_ff && f1_m_ff[63]) || (f1_neg_ff && f1_m_ff > AMP_MIN)) begin
         f2_amp_in = f1_neg_ff ? AMP_MIN : AMP_MAX;
         f2_sat_in = 1'b1;
      end else begin
         f2_amp_in = f1_neg_ff ? -f1_m_ff : f1_m_ff;
         f2_sat_in = 1'b0;
      end

      // intensity = M*M >> 24, clipped; errored beats read zero amplitude, intensity and clip flag
      sq                = pp_sum(f2_pp_ff);
      sq_over           = |sq[127:88];
      rsp_strobe_in     = f2_valid_ff;
      rsp_error_code_in = f2_err_ff;
      if (f2_err_ff != ERR_OK) begin
         rsp_amplitude_in = '0;
         rsp_intensity_in = '0;
         rsp_saturated_in = 1'b0;
      end else begin
         rsp_amplitude_in = f2_amp_ff;
         rsp_intensity_in = (f2_big_ff || sq_over) ? '1 : sq[87:24];
         rsp_saturated_in = f2_sat_ff || f2_big_ff || sq_over;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff   <= 1'b0;
         f2_valid_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         f1_valid_ff   <= f1_valid_in;
         f2_valid_ff   <= f2_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      f1_err_ff         <= f1_err_in;
      f1_neg_ff         <= f1_neg_in;
      f1_big_ff         <= f1_big_in;
      f1_m_ff           <= f1_m_in;
      f2_err_ff         <= f2_err_in;
      f2_big_ff         <= f2_big_in;
      f2_amp_ff         <= f2_amp_in;
      f2_sat_ff         <= f2_sat_in;
      f2_pp_ff          <= f2_pp_in;
      rsp_amplitude_ff  <= rsp_amplitude_in;
      rsp_intensity_ff  <= rsp_intensity_in;
      rsp_error_code_ff <= rsp_error_code_in;
      rsp_saturated_ff  <= rsp_saturated_in;
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_amplitude  = rsp_amplitude_ff;
   assign rsp_intensity  = rsp_intensity_ff;
   assign rsp_error_code = rsp_error_code_ff;
   assign rsp_saturated  = rsp_saturated_ff;

endmodule
`default_nettype wire

// ===== sim/tb_sphere_form_factor.sv =====
`timescale 1ns / 1ps
module tb_sphere_form_factor;
   import sff_pkg::*;

   localparam int          HALF_PERIOD = 2;
   localparam int          SETTLE      = 140;     // wait for the pipeline to empty, plus margin
   localparam int          STALL_LIMIT = 5000;    // cycles with no beat either way
   localparam int          RAND_PHASES = 6;
   localparam int          PHASE_ITEMS = 297;
   localparam logic [1:0]  REG_UNUSED  = 2'd3;    // write must be dropped

   // reset values (R = 1.0, c = 1.0), series threshold near q = 1677
   localparam logic [31:0] DIR_UNIT [15] = '{
      32'd0, 32'd1, 32'd1677, 32'd1678, 32'd1679, 32'd100, 32'h0100_0000,
      32'h0200_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_FFFF,
      32'h0324_3F6A, 32'h1000_0000, 32'h4000_0000};
   localparam logic [31:0] DIR_EXTREME [4] = '{32'd0, 32'd5, 32'h7FFF_FFFF, 32'h8000_0001};
   localparam logic [31:0] DIR_LARGE [5]   = '{32'd0, 32'd1, 32'd51, 32'd52, 32'h0001_0000};

   typedef struct {
      logic [63:0] amplitude;
      logic [63:0] intensity;
      logic [1:0]  error_code;
      logic        saturated;
   } ff_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [31:0] req_q_value = '0;
   logic        rsp_strobe;
   logic [63:0] rsp_amplitude;
   logic [63:0] rsp_intensity;
   logic [1:0]  rsp_error_code;
   logic        rsp_saturated;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_write_data = '0;

   // shadow copies of the block's registers
   logic [31:0] radius_reg   = REG_RESET;
   logic [31:0] contrast_reg = REG_RESET;

   logic [31:0] q_pending[$];
   ff_beat_type ff_expected[$];
   bit          idle_enable = 1'b1;
   int          mismatches = 0;
   int          quiet_cycles = 0;

   sphere_form_factor u_top (.*);

   always #HALF_PERIOD clock = ~clock;

   // atan(2^-i) in Q.62 from the truncated alternating series
   function automatic logic [63:0] arctan_q62(input int i);
      logic [63:0] acc;
      int          e;
      acc = '0;
      if (i == 0) begin
         acc = PI_Q62 >> 2;
      end else begin
         for (int k = 0; k < 64; k++) begin
            e = 62 - i * (2 * k + 1);
            if (e >= 0) begin
               if (k[0]) acc = acc - (64'd1 << e) / 64'(2 * k + 1);
               else acc = acc + (64'd1 << e) / 64'(2 * k + 1);
            end
         end
      end
      return acc;
   endfunction

   // expected amplitude, intensity, error and clip flag for one q
   function automatic ff_beat_type sphere_amplitude(input logic [31:0] q, input logic [31:0] rad,
                                                    input logic [31:0] con);
      ff_beat_type  res;
      logic [32:0]  cmag;
      logic [63:0]  x, x2, x4, x6, poly, m, r, cx, cy, cz, nx, ny, sv, cv, s0, c0;
      logic [63:0]  sa, ca;
      logic [255:0] p, t, a, b, nm, d, sq;
      logic         cneg, neg, nneg, bneg, big, sneg, cosneg;
      res = '{default: '0};
      m = '0;
      big = 1'b0;
      if (q[31]) begin
         res.error_code = ERR_NEG_Q;
         return res;
      end
      if (rad[31]) begin
         res.error_code = ERR_NEG_R;
         return res;
      end
      cneg = con[31];
      cmag = cneg ? 33'h100000000 - 33'(con) : 33'(con);
      x = 64'(q) * 64'(rad);
      neg = cneg;
      if (x < SERIES_LIMIT) begin
         x2 = (x * x) >> 18;
         x4 = 64'((256'(x2) * 256'(x2)) >> 62);
         x6 = 64'((256'(x4) * 256'(x2)) >> 62);
         poly = 64'(ONE_Q62) - x2 / 10 + x4 / 280 - x6 / 15120;
         p = 256'(cmag) * 256'(rad);
         p = p * 256'(rad);
         p = p * 256'(rad);
         p = p * 256'(FOUR_THIRDS_PI_Q60);
         p = (p * 256'(poly)) >> 162;
         big = |p[255:64];
         m = p[63:0];
      end else begin
         t = 256'(x) * 256'(TWO_OVER_PI_Q64);
         r = 64'((256'(t[103:42]) * 256'(HALF_PI_Q62)) >> 62);
         // rotation CORDIC, Q.62
         cx = INV_GAIN_Q62;
         cy = '0;
         cz = r;
         for (int i = 0; i < CORDIC_STAGES; i++) begin
            if (!cz[63]) begin
               nx = cx - 64'($signed(cy) >>> i);
               ny = cy + 64'($signed(cx) >>> i);
               cz = cz - arctan_q62(i);
            end else begin
               nx = cx + 64'($signed(cy) >>> i);
               ny = cy - 64'($signed(cx) >>> i);
               cz = cz + arctan_q62(i);
            end
            cx = nx;
            cy = ny;
         end
         s0 = cy;
         c0 = cx;
         case (t[105:104])
            2'd0: begin sv = s0; cv = c0; end
            2'd1: begin sv = c0; cv = -s0; end
            2'd2: begin sv = -s0; cv = -c0; end
            default: begin sv = -c0; cv = s0; end
         endcase
         sneg = sv[63];
         cosneg = cv[63];
         // magnitudes taken at 64 bits before widening
         sa = sneg ? -sv : sv;
         ca = cosneg ? -cv : cv;
         a = 256'(sa);
         b = (256'(x) * 256'(ca)) >> 40;
         bneg = !cosneg;
         if (sneg == bneg) begin
            nm = a + b;
            nneg = sneg;
         end else if (a >= b) begin
            nm = a - b;
            nneg = sneg;
         end else begin
            nm = b - a;
            nneg = bneg;
         end
         p = ((nm * 256'(cmag)) * 256'(PI_Q62)) >> 42;
         d = (256'(q) * 256'(q)) * 256'(q);
         if (p >= (d << 64)) big = 1'b1;
         else m = 64'(p / d);
         neg = (cneg != nneg);
      end
      if (big || (!neg && m > AMP_MAX) || (neg && m > AMP_MIN)) begin
         res.amplitude = neg ? AMP_MIN : AMP_MAX;
         res.saturated = 1'b1;
      end else begin
         res.amplitude = neg ? -m : m;
      end
      sq = (256'(m) * 256'(m)) >> 24;
      if (big || |sq[255:64]) begin
         res.intensity = '1;
         res.saturated = 1'b1;
      end else begin
         res.intensity = sq[63:0];
      end
      return res;
   endfunction

   function automatic logic [31:0] random_q();
      int roll;
      roll = $urandom_range(99);
      if (roll < 12) return $urandom();                      // may be negative
      if (roll < 35) return 32'($urandom_range(4095));       // around the series limit
      if (roll < 50) return $urandom() & 32'h7FFFFFFF;
      return ($urandom() & 32'h7FFFFFFF) >> $urandom_range(31);
   endfunction

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      if (idx == REG_RADIUS) radius_reg = value;
      else if (idx == REG_CONTRAST) contrast_reg = value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // hold off until the pipe has drained completely
   task automatic drain();
      while (q_pending.size() != 0 || start || ff_expected.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // driver: start/q beats with random gaps; expectation recorded on accept
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            ff_expected.push_back(sphere_amplitude(req_q_value, radius_reg, contrast_reg));
         end
         if (!start || !busy) begin
            if (q_pending.size() != 0 && !(idle_enable && $urandom_range(99) < 30)) begin
               start       <= 1'b1;
               req_q_value <= q_pending.pop_front();
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(input string name, input logic [63:0] exp_v,
                              input logic [63:0] act_v);
      if (exp_v !== act_v) begin
         mismatches++;
         if (mismatches <= 10)
            $display("MISMATCH %s: expected %h, got %h", name, exp_v, act_v);
      end
   endtask

   // monitor: each strobed beat against the oldest expectation
   always @(posedge clock) begin
      ff_beat_type want;
      if (!reset && rsp_strobe) begin
         if (ff_expected.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("MISMATCH: result beat with nothing expected");
         end else begin
            want = ff_expected.pop_front();
            check_field("amplitude", want.amplitude, rsp_amplitude);
            check_field("intensity", want.intensity, rsp_intensity);
            check_field("error_code", 64'(want.error_code), 64'(rsp_error_code));
            check_field("saturated", 64'(want.saturated), 64'(rsp_saturated));
         end
      end
   end

   // watchdog: too long without a beat on either side
   always @(posedge clock) begin
      if (reset || rsp_strobe || (start && !busy)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [31:0] rad, con;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: reset values, series threshold
      foreach (DIR_UNIT[i])
         q_pending.push_back(DIR_UNIT[i]);
      drain();
      // extremes: zero radius, most negative contrast, ignored register index
      write_reg(REG_RADIUS, 32'd0);
      write_reg(REG_CONTRAST, 32'h8000_0000);
      write_reg(REG_UNUSED, 32'h1234_5678);
      foreach (DIR_EXTREME[i])
         q_pending.push_back(DIR_EXTREME[i]);
      drain();
      // largest radius and contrast: series overflow and saturation
      write_reg(REG_RADIUS, 32'h7FFF_FFFF);
      write_reg(REG_CONTRAST, 32'h7FFF_FFFF);
      foreach (DIR_LARGE[i])
         q_pending.push_back(DIR_LARGE[i]);
      drain();

      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         case (ph)
            0: begin rad = 32'h8000_0000 | $urandom(); con = $urandom(); end  // negative R
            1: begin rad = 32'(1 << $urandom_range(20)); con = 32'd0; end
            2: begin rad = 32'h7FFF_FFFF; con = 32'h8000_0000; end
            3: begin rad = $urandom_range(32'h0004_0000); con = $urandom(); end
            default: begin
               rad = ($urandom() & 32'h7FFF_FFFF) >> $urandom_range(31);
               con = $urandom();
            end
         endcase
         write_reg(REG_CONTRAST, con);
         write_reg(REG_RADIUS, rad);
         idle_enable = (ph != 4);  // one long back-to-back stretch
         for (int n = 0; n < (ph == 0 ? 40 : PHASE_ITEMS); n++)
            q_pending.push_back(random_q());
         drain();
      end

      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
